// ===== sv/assert_macros.svh =====
// concurrent assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CSVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CSVN_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CSVN_ASSERT(lbl, prop, msg)

`define CSVN_NEVER(lbl, cond, msg)

`endif

`endif

// ===== sv/csvn_pkg.sv =====
package csvn_pkg;

  localparam int PHASE_BITS = 12;
  localparam int INDEX_BITS = 12;

  // segment number k = i or i+1, one bit wider than the index
  localparam int KW         = INDEX_BITS + 1;
  localparam int NW         = 13;
  localparam int DIV_STAGES = KW + PHASE_BITS;

  localparam int QW_SIZE  = 1 << (PHASE_BITS - 2);
  localparam int QW_DEPTH = QW_SIZE + 1;
  localparam int QW_AW    = PHASE_BITS - 1;
  localparam int QW_DW    = 15;

  localparam int CFG_CONE_HEIGHT   = 0;
  localparam int CFG_BASE_RADIUS   = 1;
  localparam int CFG_SEGMENT_COUNT = 2;

  typedef logic [KW-1:0]         kval_t;
  typedef logic [NW-1:0]         nval_t;
  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [QW_AW-1:0]      qw_addr_t;
  typedef logic [QW_DW-1:0]      qw_data_t;
  typedef qw_data_t              qw_rom_t [QW_DEPTH];

  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

  // (2n)(2n+1) for the taylor terms of sine
  localparam logic [63:0] SeriesDiv [13] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(32767 * sin(pi/2 * q / QW_SIZE)) with a q62 integer taylor series
  function automatic qw_data_t quarter_entry(input logic [63:0] q);
    logic [63:0]  frac;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] prod;
    frac = PI_HALF_Q62 & ((64'd1 << (PHASE_BITS - 2)) - 64'd1);
    x    = (PI_HALF_Q62 >> (PHASE_BITS - 2)) * q + ((frac * q) >> (PHASE_BITS - 2));
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 13; n++) begin
      term = mul_q62(term, x2) / SeriesDiv[n-1];
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    prod = {64'd0, sum} * 128'd32767 + (128'd1 << 61);
    return prod[62+QW_DW-1:62];
  endfunction

  function automatic qw_rom_t gen_quarter_table();
    qw_rom_t t;
    for (int q = 0; q < QW_DEPTH; q++) begin
      t[q] = quarter_entry(64'(q));
    end
    return t;
  endfunction

endpackage

// ===== sv/cone_segment_vertex_normal.sv =====
// one side triangle of a tessellated cone per input beat
// input channel: in_segment_index with in_valid / in_ready, one beat per segment i
// result channel: rim points i and i+1 (signed q8.8) and the cross-product
//   normal of (apex, p_i, p_i+1) in units of 2^-16, with out_valid / out_ready
// config port: cfg_we / cfg_index / cfg_data writes cone height, base radius
//   and segment count; write only while no beat is in flight
// latency: 32 cycles from input accept to out_valid; 25 of them are the
//   bit-per-stage phase dividers, then table read, radius scale, rounding,
//   deltas, products and the output register
// throughput: one beat per cycle, the whole pipeline moves as one
// stall: while out_valid is high and out_ready low every stage holds and
//   in_ready drops; nothing is lost or repeated
// reset: synchronous active-low rst_n clears the valid bits and sets
//   height 0, radius 0, segment count 1 (a count of zero acts as one)
module cone_segment_vertex_normal (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [csvn_pkg::INDEX_BITS-1:0] in_segment_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [16:0]   out_first_x,
  output logic signed [16:0]   out_first_y,
  output logic signed [16:0]   out_second_x,
  output logic signed [16:0]   out_second_y,
  output logic signed [33:0]   out_normal_x,
  output logic signed [33:0]   out_normal_y,
  output logic signed [34:0]   out_normal_z,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import csvn_pkg::*;
  `include "assert_macros.svh"

  localparam int LAT = DIV_STAGES + 6;

  logic [15:0] cone_height_r;
  logic [15:0] base_radius_r;
  nval_t       segment_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cone_height_r   <= '0;
      base_radius_r   <= '0;
      segment_count_r <= nval_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        2'(CFG_CONE_HEIGHT):   cone_height_r   <= cfg_data;
        2'(CFG_BASE_RADIUS):   base_radius_r   <= cfg_data;
        2'(CFG_SEGMENT_COUNT): segment_count_r <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // phase dividers for k = i and k = i+1
  nval_t  n_eff;
  kval_t  k1;
  kval_t  k2;
  phase_t p1;
  phase_t p2;

  assign n_eff = (segment_count_r == '0) ? nval_t'(1) : segment_count_r;
  assign k1    = kval_t'(in_segment_index[INDEX_BITS-1:0]);
  assign k2    = k1 + kval_t'(1);

  csvn_div u_div1 (.clk(clk), .en(en), .k(k1), .n(n_eff), .phase(p1));
  csvn_div u_div2 (.clk(clk), .en(en), .k(k2), .n(n_eff), .phase(p2));

  // lanes: 0 x1 (cos p1), 1 y1 (sin p1), 2 x2 (cos p2), 3 y2 (sin p2)
  phase_t   ph   [4];
  logic [1:0] quad [4];
  qw_addr_t addr [4];
  logic [3:0] neg;

  always_comb begin
    ph[0] = p1;
    ph[1] = p1;
    ph[2] = p2;
    ph[3] = p2;
    for (int l = 0; l < 4; l++) begin
      // cosine is the sine a quarter turn further on
      quad[l] = ph[l][PHASE_BITS-1:PHASE_BITS-2] + ((l % 2 == 0) ? 2'd1 : 2'd0);
      if (quad[l][0]) begin
        addr[l] = qw_addr_t'(QW_SIZE) - {1'b0, ph[l][PHASE_BITS-3:0]};
      end else begin
        addr[l] = {1'b0, ph[l][PHASE_BITS-3:0]};
      end
      neg[l] = quad[l][1];
    end
  end

  qw_data_t rom_q [4];

  csvn_rom u_rom1 (
    .clk(clk), .en(en), .rd_addr_a(addr[0]), .rd_addr_b(addr[1]),
    .rd_data_a(rom_q[0]), .rd_data_b(rom_q[1])
  );
  csvn_rom u_rom2 (
    .clk(clk), .en(en), .rd_addr_a(addr[2]), .rd_addr_b(addr[3]),
    .rd_data_a(rom_q[2]), .rd_data_b(rom_q[3])
  );

  logic [3:0]  neg_t1_r;
  logic [3:0]  neg_t2_r;
  logic [3:0]  neg_t3_r;
  logic [30:0] prod_t2_r [4];
  logic [16:0] hi_t3_r   [4];
  logic [17:0] s_t3_r    [4];
  logic signed [16:0] pt_t4_r [4];

  logic [31:0] c_t3      [4];
  logic [2:0]  a2_t4     [4];
  logic [15:0] t_t4      [4];
  logic [16:0] mag_t4    [4];

  // round(r * t / 32767) as floor((r*t + 16383) / 32767), folding 2^15 = 32767 + 1
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      c_t3[l]   = 32'(prod_t2_r[l]) + 32'd16383;
      a2_t4[l]  = s_t3_r[l][17:15];
      t_t4[l]   = 16'(a2_t4[l]) + 16'(s_t3_r[l][14:0]);
      mag_t4[l] = hi_t3_r[l] + 17'(a2_t4[l]) + 17'(t_t4[l] >= 16'd32767);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_t1_r <= neg;
      neg_t2_r <= neg_t1_r;
      neg_t3_r <= neg_t2_r;
      for (int l = 0; l < 4; l++) begin
        prod_t2_r[l] <= 31'(base_radius_r) * 31'(rom_q[l]);
        hi_t3_r[l]   <= c_t3[l][31:15];
        s_t3_r[l]    <= 18'(c_t3[l][31:15]) + 18'(c_t3[l][14:0]);
        pt_t4_r[l]   <= neg_t3_r[l] ? -$signed(mag_t4[l]) : $signed(mag_t4[l]);
      end
    end
  end

  logic signed [16:0] x1_t5_r, y1_t5_r, x2_t5_r, y2_t5_r;
  logic signed [17:0] dx_t5_r, dy_t5_r;
  logic signed [16:0] x1_t6_r, y1_t6_r, x2_t6_r, y2_t6_r;
  logic signed [34:0] hdy_t6_r, hdx_t6_r, ydx_t6_r, xdy_t6_r;
  logic signed [16:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic signed [33:0] normal_x_r, normal_y_r;
  logic signed [34:0] normal_z_r;
  logic signed [16:0] h_s;
  logic signed [34:0] nx_full;
  logic signed [35:0] nz_full;

  assign h_s     = $signed({1'b0, cone_height_r});
  assign nx_full = -hdy_t6_r;
  assign nz_full = 36'(ydx_t6_r) - 36'(xdy_t6_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_t5_r <= pt_t4_r[0];
      y1_t5_r <= pt_t4_r[1];
      x2_t5_r <= pt_t4_r[2];
      y2_t5_r <= pt_t4_r[3];
      dx_t5_r <= 18'(pt_t4_r[2]) - 18'(pt_t4_r[0]);
      dy_t5_r <= 18'(pt_t4_r[3]) - 18'(pt_t4_r[1]);

      x1_t6_r  <= x1_t5_r;
      y1_t6_r  <= y1_t5_r;
      x2_t6_r  <= x2_t5_r;
      y2_t6_r  <= y2_t5_r;
      hdy_t6_r <= 35'(h_s) * 35'(dy_t5_r);
      hdx_t6_r <= 35'(h_s) * 35'(dx_t5_r);
      ydx_t6_r <= 35'(y1_t5_r) * 35'(dx_t5_r);
      xdy_t6_r <= 35'(x1_t5_r) * 35'(dy_t5_r);

      first_x_r  <= x1_t6_r;
      first_y_r  <= y1_t6_r;
      second_x_r <= x2_t6_r;
      second_y_r <= y2_t6_r;
      normal_x_r <= nx_full[33:0];
      normal_y_r <= hdx_t6_r[33:0];
      normal_z_r <= nz_full[34:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_first_x  = first_x_r;
  assign out_first_y  = first_y_r;
  assign out_second_x = second_x_r;
  assign out_second_y = second_y_r;
  assign out_normal_x = normal_x_r;
  assign out_normal_y = normal_y_r;
  assign out_normal_z = normal_z_r;

  logic signed [17:0] rad_s;
  logic rim_in_radius;
  logic flat_beat;
  logic side_zero;
  logic zero_rad_beat;
  logic rim_zero;

  assign rad_s         = $signed({2'b00, base_radius_r});
  assign rim_in_radius = (18'(first_x_r) <= rad_s) && (18'(first_x_r) >= -rad_s) &&
                         (18'(second_y_r) <= rad_s) && (18'(second_y_r) >= -rad_s);
  assign flat_beat     = out_valid_r && (cone_height_r == '0);
  assign side_zero     = (normal_x_r == '0) && (normal_y_r == '0);
  assign zero_rad_beat = out_valid_r && (base_radius_r == '0);
  assign rim_zero      = (first_x_r == '0) && (second_y_r == '0) && (normal_z_r == '0);

  `CSVN_ASSERT(a_rim_in_radius, out_valid_r |-> rim_in_radius, "rim point outside base radius")
  `CSVN_ASSERT(a_flat_cone_normal, flat_beat |-> side_zero, "nonzero side normal at zero height")
  `CSVN_ASSERT(a_zero_radius, zero_rad_beat |-> rim_zero, "nonzero rim at zero radius")

endmodule

// ===== sv/csvn_rom.sv =====
module csvn_rom (
  input  logic               clk,
  input  logic               en,
  input  csvn_pkg::qw_addr_t rd_addr_a,
  input  csvn_pkg::qw_addr_t rd_addr_b,
  output csvn_pkg::qw_data_t rd_data_a,
  output csvn_pkg::qw_data_t rd_data_b
);
  import csvn_pkg::*;

  localparam qw_rom_t QW_ROM = gen_quarter_table();

  qw_data_t rd_a_r;
  qw_data_t rd_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a_r <= QW_ROM[rd_addr_a];
      rd_b_r <= QW_ROM[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/csvn_div.sv =====
module csvn_div (
  input  logic            clk,
  input  logic            en,
  input  csvn_pkg::kval_t k,
  input  csvn_pkg::nval_t n,
  output csvn_pkg::phase_t phase
);
  import csvn_pkg::*;

  // restoring division of k * 2^PHASE_BITS by n, one quotient bit per stage
  nval_t  rem_r [DIV_STAGES];
  kval_t  k_r   [DIV_STAGES];
  phase_t q_r   [DIV_STAGES];

  nval_t        rem_nxt [DIV_STAGES];
  kval_t        k_nxt   [DIV_STAGES];
  phase_t       q_nxt   [DIV_STAGES];
  nval_t        rem_in  [DIV_STAGES];
  kval_t        k_in    [DIV_STAGES];
  phase_t       q_in    [DIV_STAGES];
  logic [NW:0]  sh      [DIV_STAGES];
  logic [NW:0]  diff    [DIV_STAGES];

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem_in[s] = '0;
        k_in[s]   = k;
        q_in[s]   = '0;
      end else begin
        rem_in[s] = rem_r[s-1];
        k_in[s]   = k_r[s-1];
        q_in[s]   = q_r[s-1];
      end
      // dividend bits: k first, then zeros from the left shift
      sh[s]   = {rem_in[s], k_in[s][KW-1]};
      diff[s] = sh[s] - {1'b0, n};
      k_nxt[s] = {k_in[s][KW-2:0], 1'b0};
      if (sh[s] >= {1'b0, n}) begin
        rem_nxt[s] = diff[s][NW-1:0];
        q_nxt[s]   = {q_in[s][PHASE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[s] = sh[s][NW-1:0];
        q_nxt[s]   = {q_in[s][PHASE_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        k_r[s]   <= k_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  assign phase = q_r[DIV_STAGES-1];

endmodule

// ===== bench/cone_segment_vertex_normal_check.sv =====
`timescale 1ns / 1ps

module cone_segment_vertex_normal_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [11:0]         in_segment_index,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [16:0]  out_first_x,
  input  logic signed [16:0]  out_first_y,
  input  logic signed [16:0]  out_second_x,
  input  logic signed [16:0]  out_second_y,
  input  logic signed [33:0]  out_normal_x,
  input  logic signed [33:0]  out_normal_y,
  input  logic signed [34:0]  out_normal_z,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  outstanding,
  output int                  fail_count
);
  import csvn_pkg::*;

  typedef struct {
    logic signed [16:0] x1, y1, x2, y2;
    logic signed [33:0] nx, ny;
    logic signed [34:0] nz;
  } triangle_t;

  localparam logic [63:0] HALF_PI = 64'h6487ED5110B4611A;

  longint    sine_quarter [1025];
  triangle_t triangle_q [$];
  longint    height = 0;
  longint    radius = 0;
  longint    segs   = 1;

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // taylor series in q62, scaled by 32767 and rounded
  function automatic longint sine_entry(longint q);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [127:0] p;
    x = (HALF_PI >> 10) * 64'(q) + (((HALF_PI & 64'd1023) * 64'(q)) >> 10);
    x2 = q62_mul(x, x);
    term = x;
    acc = x;
    for (int n = 1; n <= 13; n++) begin
      term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2) acc = acc - term;
      else acc = acc + term;
    end
    p = {64'd0, acc} * 128'd32767 + (128'd1 << 61);
    return longint'(p[125:62]);
  endfunction

  initial begin
    for (int q = 0; q <= 1024; q++) sine_quarter[q] = sine_entry(q);
  end

  function automatic longint wave(longint p);
    longint quad;
    longint r;
    longint v;
    quad = (p >> 10) & 3;
    r = p & 1023;
    v = (quad & 1) ? sine_quarter[1024 - r] : sine_quarter[r];
    return (quad & 2) ? -v : v;
  endfunction

  function automatic longint scaled(longint t);
    longint mag;
    longint v;
    mag = t < 0 ? -t : t;
    v = (radius * mag * 2 + 32767) / 65534;
    return t < 0 ? -v : v;
  endfunction

  function automatic triangle_t cone_triangle(logic [11:0] idx);
    longint n;
    longint p1;
    longint p2;
    longint x1, y1, x2, y2, dx, dy;
    triangle_t t;
    n = (segs == 0) ? 1 : segs;
    p1 = ((longint'(idx) << 12) / n) & 4095;
    p2 = (((longint'(idx) + 1) << 12) / n) & 4095;
    x1 = scaled(wave((p1 + 1024) & 4095));
    y1 = scaled(wave(p1));
    x2 = scaled(wave((p2 + 1024) & 4095));
    y2 = scaled(wave(p2));
    dx = x2 - x1;
    dy = y2 - y1;
    t.x1 = 17'(x1);
    t.y1 = 17'(y1);
    t.x2 = 17'(x2);
    t.y2 = 17'(y2);
    t.nx = 34'(-(height * dy));
    t.ny = 34'(height * dx);
    t.nz = 35'(y1 * dx - x1 * dy);
    return t;
  endfunction

  always @(posedge clk) begin
    triangle_t want;
    int delta;
    delta = 0;
    if (rst_n) begin
      if (cfg_we) begin
        case (int'(cfg_index))
          CFG_CONE_HEIGHT:   height = cfg_data;
          CFG_BASE_RADIUS:   radius = cfg_data;
          CFG_SEGMENT_COUNT: segs = cfg_data & 16'h1FFF;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        triangle_q.push_back(cone_triangle(in_segment_index));
        delta++;
      end
      if (out_valid && out_ready) begin
        if (triangle_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = triangle_q.pop_front();
          delta--;
          if (out_first_x !== want.x1 || out_first_y !== want.y1 ||
              out_second_x !== want.x2 || out_second_y !== want.y2 ||
              out_normal_x !== want.nx || out_normal_y !== want.ny ||
              out_normal_z !== want.nz) begin
            if (out_first_x !== want.x1)
              $error("first_x expected %0d got %0d", want.x1, out_first_x);
            if (out_first_y !== want.y1)
              $error("first_y expected %0d got %0d", want.y1, out_first_y);
            if (out_second_x !== want.x2)
              $error("second_x expected %0d got %0d", want.x2, out_second_x);
            if (out_second_y !== want.y2)
              $error("second_y expected %0d got %0d", want.y2, out_second_y);
            if (out_normal_x !== want.nx)
              $error("normal_x expected %0d got %0d", want.nx, out_normal_x);
            if (out_normal_y !== want.ny)
              $error("normal_y expected %0d got %0d", want.ny, out_normal_y);
            if (out_normal_z !== want.nz)
              $error("normal_z expected %0d got %0d", want.nz, out_normal_z);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import csvn_pkg::*;

  localparam int CFG_NO_REG   = 3;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [11:0]         in_segment_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [16:0]  out_first_x, out_first_y, out_second_x, out_second_y;
  logic signed [33:0]  out_normal_x, out_normal_y;
  logic signed [34:0]  out_normal_z;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  int                  outstanding;
  int                  fail_count;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_on = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  int seg_now = 1;

  always #5 clk = ~clk;

  cone_segment_vertex_normal i_dut (.*);

  cone_segment_vertex_normal_check i_check (.*);

  // receiver: random stall, plus one long hold-off to back the pipe up
  always @(posedge clk) begin
    if (hold_on && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cone_segment_vertex_normal verification failed");
      $finish;
    end
  end

  task automatic send_segment(logic [11:0] idx);
    in_valid <= 1'b1;
    in_segment_index <= idx;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] h, logic [15:0] r, logic [15:0] n);
    cfg_we <= 1'b1;
    cfg_index <= 2'(CFG_CONE_HEIGHT);
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= 2'(CFG_BASE_RADIUS);
    cfg_data <= r;
    @(posedge clk);
    cfg_index <= 2'(CFG_SEGMENT_COUNT);
    cfg_data <= n;
    @(posedge clk);
    // ignored write to the unused index
    cfg_index <= 2'(CFG_NO_REG);
    cfg_data <= 16'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    seg_now = (n & 16'h1FFF) == 0 ? 1 : (n & 16'h1FFF);
  endtask

  task automatic random_segments(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 1) || seg_now > 4096) send_segment(12'($urandom_range(0, 4095)));
      else send_segment(12'($urandom_range(0, seg_now - 1)));
    end
  endtask

  initial begin
    logic [15:0] hs [10];
    logic [15:0] rs [10];
    logic [15:0] ns [10];
    logic [11:0] corner [12];
    hs = '{16'hFFFF, 16'h0100, 16'hFFFF, 16'h0000, 16'h1234, 0, 0, 0, 0, 16'hFFFF};
    rs = '{16'hFFFF, 16'h0100, 16'hFFFF, 16'hFFFF, 16'h0001, 0, 0, 0, 0, 16'h8000};
    ns = '{16'd4096, 16'd8, 16'd1, 16'd0, 16'd8191, 0, 0, 0, 0, 16'h2000};
    corner = '{12'd0, 12'd1, 12'd1023, 12'd1024, 12'd2047, 12'd2048, 12'd3071,
               12'd3072, 12'd4094, 12'd4095, 12'hAAA, 12'h555};
    for (int p = 5; p < 9; p++) begin
      hs[p] = 16'($urandom_range(0, 65535));
      rs[p] = 16'($urandom_range(0, 65535));
      ns[p] = (p == 8) ? 16'($urandom_range(4097, 65535)) : 16'($urandom_range(1, 64));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero height and radius, one segment
    send_segment(12'd0);
    send_segment(12'd4095);
    drain();

    write_regs(16'hFFFF, 16'hFFFF, 16'd4096);
    foreach (corner[j]) send_segment(corner[j]);
    drain();
    write_regs(16'h0, 16'hFFFF, 16'd3);
    for (int j = 0; j < 4; j++) send_segment(12'(j));
    send_segment(12'd4095);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_regs(hs[p], rs[p], ns[p]);
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 66; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 66; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      if (p == 4) hold_on = 1'b1;
      random_segments(163);
      drain();
    end

    if (fail_count == 0) begin
      $display("cone_segment_vertex_normal verification clean");
    end else begin
      $display("cone_segment_vertex_normal verification failed");
    end
    $finish;
  end

endmodule

// ===== cone_segment_vertex_normal.f =====
+incdir+sv
sv/csvn_pkg.sv
sv/csvn_rom.sv
sv/csvn_div.sv
sv/cone_segment_vertex_normal.sv
bench/cone_segment_vertex_normal_check.sv
bench/tb.sv
